/* hdl/amcr_pkg.sv */
// shared constants, codes and types for the affine midpoint circle rasterizer
// no dependencies; imported by affine_midpoint_circle_raster and the testbench
`default_nettype none

package amcr_pkg;

  localparam int RADIUS_BITS = 12;
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;

  // fixed field widths
  localparam int MAT_BITS    = 32;
  localparam int CX_BITS     = 16;
  localparam int RAD_IN_BITS = 12;
  localparam int OCT_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;

  // derived widths
  localparam int DEC_BITS  = RADIUS_BITS + 4;
  localparam int PT_BITS   = ((COORD_BITS > RADIUS_BITS + 1) ? COORD_BITS : RADIUS_BITS + 1) + 1;
  localparam int PROD_BITS = MAT_BITS + PT_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;

  // stream packing
  localparam int S_TDATA_BITS = 48;
  localparam int M_TDATA_BITS = 72;
  localparam int M_TUSER_BITS = 2;

  localparam logic [MAT_BITS-1:0] MAT_ONE = MAT_BITS'(1) << FRAC_BITS;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAT_A  = 3'd0,
    REG_MAT_B  = 3'd1,
    REG_MAT_TX = 3'd2,
    REG_MAT_C  = 3'd3,
    REG_MAT_D  = 3'd4,
    REG_MAT_TY = 3'd5
  } cfg_reg_t;

  localparam logic [OCT_BITS-1:0] OCT_FIRST = '0;
  localparam logic [OCT_BITS-1:0] OCT_LAST  = '1;

  // per-result tag carried down the pipeline
  typedef struct packed {
    logic [OCT_BITS-1:0] octant;
    logic                point_valid;
    logic                last_of_step;
    logic                circle_done;
  } res_tag_t;

  // reflections in result order: bit 2 swaps x and y, bit 1 negates the
  // x offset, bit 0 negates the y offset
  function automatic logic oct_swap(input logic [OCT_BITS-1:0] oct);
    return oct[2];
  endfunction

  function automatic logic oct_neg_x(input logic [OCT_BITS-1:0] oct);
    return oct[1];
  endfunction

  function automatic logic oct_neg_y(input logic [OCT_BITS-1:0] oct);
    return oct[0];
  endfunction

endpackage

`default_nettype wire

/* hdl/affine_midpoint_circle_raster.sv */
// top level: midpoint circle stepper, octant sequencer and affine pipeline
// depends on amcr_pkg
`default_nettype none

// usage
//   slave stream: s_tuser is kind (start or advance), s_tdata carries the
//   center and radius used by a start. every accepted item runs one midpoint
//   step. a step with points left gives eight results, one per octant; a
//   step with nothing left (or an advance while idle) gives one result with
//   point_valid low, circle_done high and zero coordinates.
//   master stream: one result per transfer, m_tlast marks the last result of
//   the step. each point is multiplied by the 2x3 matrix from the config port
//   and saturated to signed 32-bit Q16.16.
//   config port: cfg_we writes cfg_data to the register at cfg_index; write
//   only while no step is in flight.
// timing
//   first result of an item passes through the sequencer, point stage and
//   multiply stage registers into the output register, which drives m_tvalid.
//   an item gives eight results when it draws and one when it ends the circle;
//   the octant sequencer emits one result per cycle unless m_tready stalls it.
//   the next item is taken in the cycle the sequencer issues the last octant.
// reset
//   rst clears the stepper (idle, nothing drawing), empties the pipeline and
//   loads the identity matrix.
// stalls
//   m_tready low with m_tvalid high freezes the pipeline and sequencer; s_tready
//   drops while a job is held until the output can move again. nothing is dropped.
module affine_midpoint_circle_raster (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave stream
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  // center_x [15:0], center_y [31:16], radius [43:32], zero pad
  input  wire logic [amcr_pkg::S_TDATA_BITS-1:0]  s_tdata,
  // kind [0]
  input  wire logic                               s_tuser,
  // master stream
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  // point_x [31:0], point_y [63:32], octant [66:64], zero pad
  output      logic [amcr_pkg::M_TDATA_BITS-1:0]  m_tdata,
  // point_valid [0], circle_done [1]
  output      logic [amcr_pkg::M_TUSER_BITS-1:0]  m_tuser,
  // last_of_step
  output      logic                               m_tlast,
  // config write port
  input  wire logic                               cfg_we,
  input  wire logic [amcr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [amcr_pkg::MAT_BITS-1:0]      cfg_data
);

  import amcr_pkg::*;

  // matrix registers
  logic [MAT_BITS-1:0] mat_a, mat_b, mat_tx, mat_c, mat_d, mat_ty;

  // stepper state
  logic [RADIUS_BITS-1:0]   step_x, step_y;
  logic signed [DEC_BITS-1:0] decision;
  logic signed [COORD_BITS-1:0] held_center_x, held_center_y;
  logic                     drawing;

  // octant sequencer (one job = one step's worth of results)
  logic                         job_valid;
  logic                         job_done;
  logic [RADIUS_BITS-1:0]       job_x, job_y;
  logic signed [COORD_BITS-1:0] job_cx, job_cy;
  logic [OCT_BITS-1:0]          job_oct;

  // point stage
  logic                      s1_valid;
  logic signed [PT_BITS-1:0] s1_px, s1_py;
  res_tag_t                  s1_tag;

  // multiply stage
  logic                        s2_valid;
  logic signed [PROD_BITS-1:0] s2_ax, s2_by, s2_cx, s2_dy;
  res_tag_t                    s2_tag;

  // output register
  logic [MAT_BITS-1:0] out_x, out_y;
  res_tag_t            out_tag;

  logic pipe_en;
  logic job_finish;
  logic in_xfer;

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  assign pipe_en    = !m_tvalid || m_tready;
  assign job_finish = job_valid && pipe_en && (job_done || job_oct == OCT_LAST);
  assign s_tready   = !job_valid || job_finish;
  assign in_xfer    = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_a  <= MAT_ONE;
      mat_b  <= '0;
      mat_tx <= '0;
      mat_c  <= '0;
      mat_d  <= MAT_ONE;
      mat_ty <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAT_A:  mat_a  <= cfg_data;
        REG_MAT_B:  mat_b  <= cfg_data;
        REG_MAT_TX: mat_tx <= cfg_data;
        REG_MAT_C:  mat_c  <= cfg_data;
        REG_MAT_D:  mat_d  <= cfg_data;
        REG_MAT_TY: mat_ty <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // midpoint step, evaluated on the incoming item
  // ---------------------------------------------------------------------
  logic                         in_start;
  logic [RADIUS_BITS-1:0]       in_radius;
  logic [RADIUS_BITS-1:0]       eff_x, eff_y, x_next, y_dec;
  logic signed [DEC_BITS-1:0]   eff_d, inc, two_y, d_next;
  logic signed [COORD_BITS-1:0] eff_cx, eff_cy;
  logic                         eff_draw, run;

  assign in_start  = (s_tuser == KIND_START);
  assign in_radius = s_tdata[CX_BITS*2 +: RADIUS_BITS];

  always_comb begin
    if (in_start) begin
      eff_x  = '0;
      eff_y  = in_radius;
      eff_d  = DEC_BITS'(signed'(1)) - $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, in_radius});
      eff_cx = $signed(s_tdata[COORD_BITS-1:0]);
      eff_cy = $signed(s_tdata[CX_BITS +: COORD_BITS]);
    end else begin
      eff_x  = step_x;
      eff_y  = step_y;
      eff_d  = decision;
      eff_cx = held_center_x;
      eff_cy = held_center_y;
    end
    eff_draw = in_start || drawing;
    run      = eff_draw && (eff_x < eff_y);

    x_next = eff_x + RADIUS_BITS'(1);
    y_dec  = eff_y - RADIUS_BITS'(1);
    // 2x+1 and 2y with the updated x and y
    inc    = $signed({{(DEC_BITS-RADIUS_BITS-1){1'b0}}, x_next, 1'b1});
    two_y  = $signed({{(DEC_BITS-RADIUS_BITS-1){1'b0}}, y_dec, 1'b0});
    if (eff_d < 0) begin
      d_next = eff_d + inc;
    end else begin
      d_next = eff_d + inc - two_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      drawing       <= 1'b0;
    end else if (in_xfer) begin
      held_center_x <= eff_cx;
      held_center_y <= eff_cy;
      drawing       <= run;
      if (run) begin
        step_x   <= x_next;
        step_y   <= (eff_d < 0) ? eff_y : y_dec;
        decision <= d_next;
      end else begin
        step_x   <= eff_x;
        step_y   <= eff_y;
        decision <= eff_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // octant sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_xfer) begin
      job_valid <= 1'b1;
    end else if (job_finish) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      job_done <= !run;
      job_x    <= eff_x;
      job_y    <= eff_y;
      job_cx   <= eff_cx;
      job_cy   <= eff_cy;
      job_oct  <= OCT_FIRST;
    end else if (job_valid && pipe_en) begin
      job_oct  <= job_oct + OCT_BITS'(1);
    end
  end

  // ---------------------------------------------------------------------
  // point stage: reflect (x, y) about the center
  // ---------------------------------------------------------------------
  logic [RADIUS_BITS-1:0]    ref_u, ref_v;
  logic signed [PT_BITS-1:0] ext_cx, ext_cy, ext_u, ext_v, pt_x, pt_y;
  res_tag_t                  pt_tag;

  always_comb begin
    ref_u  = oct_swap(job_oct) ? job_y : job_x;
    ref_v  = oct_swap(job_oct) ? job_x : job_y;
    ext_cx = PT_BITS'(job_cx);
    ext_cy = PT_BITS'(job_cy);
    ext_u  = $signed({{(PT_BITS-RADIUS_BITS){1'b0}}, ref_u});
    ext_v  = $signed({{(PT_BITS-RADIUS_BITS){1'b0}}, ref_v});
    pt_x   = oct_neg_x(job_oct) ? ext_cx - ext_u : ext_cx + ext_u;
    pt_y   = oct_neg_y(job_oct) ? ext_cy - ext_v : ext_cy + ext_v;
    if (job_done) begin
      pt_x = '0;
      pt_y = '0;
      pt_tag = '{octant: OCT_FIRST, point_valid: 1'b0, last_of_step: 1'b1,
                 circle_done: 1'b1};
    end else begin
      pt_tag = '{octant: job_oct, point_valid: 1'b1,
                 last_of_step: (job_oct == OCT_LAST), circle_done: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_px  <= pt_x;
      s1_py  <= pt_y;
      s1_tag <= pt_tag;
    end
  end

  // ---------------------------------------------------------------------
  // multiply stage: four 32 x 17 products in parallel
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s2_valid <= s1_valid;
    end
  end

  // operands sign extended to the full product width
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_ax  <= PROD_BITS'($signed(mat_a)) * PROD_BITS'(s1_px);
      s2_by  <= PROD_BITS'($signed(mat_b)) * PROD_BITS'(s1_py);
      s2_cx  <= PROD_BITS'($signed(mat_c)) * PROD_BITS'(s1_px);
      s2_dy  <= PROD_BITS'($signed(mat_d)) * PROD_BITS'(s1_py);
      s2_tag <= s1_tag;
    end
  end

  // ---------------------------------------------------------------------
  // sum, translate and saturate into the output register
  // ---------------------------------------------------------------------
  logic signed [SUM_BITS-1:0] sum_x, sum_y;
  logic [MAT_BITS-1:0]        sat_x, sat_y;

  function automatic logic [MAT_BITS-1:0] sat32(input logic signed [SUM_BITS-1:0] v);
    logic upper_ok;
    upper_ok = (v[SUM_BITS-1:MAT_BITS-1] == '0) || (v[SUM_BITS-1:MAT_BITS-1] == '1);
    if (upper_ok) begin
      return v[MAT_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      return {1'b1, {(MAT_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(MAT_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    sum_x = SUM_BITS'(s2_ax) + SUM_BITS'(s2_by) + SUM_BITS'($signed(mat_tx));
    sum_y = SUM_BITS'(s2_cx) + SUM_BITS'(s2_dy) + SUM_BITS'($signed(mat_ty));
    // an end-of-circle result carries zero coordinates
    sat_x = s2_tag.point_valid ? sat32(sum_x) : '0;
    sat_y = s2_tag.point_valid ? sat32(sum_y) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_x   <= sat_x;
      out_y   <= sat_y;
      out_tag <= s2_tag;
    end
  end

  assign m_tdata = {{(M_TDATA_BITS-2*MAT_BITS-OCT_BITS){1'b0}}, out_tag.octant, out_y, out_x};
  assign m_tuser = {out_tag.circle_done, out_tag.point_valid};
  assign m_tlast = out_tag.last_of_step;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // an accepted item always leaves a job in the sequencer
  a_xfer_loads_job: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> job_valid)
    else $error("accepted item did not load the sequencer");

  // drawing only turns on through a start item
  a_drawing_needs_start: assert property (@(posedge clk) disable iff (rst)
    !drawing && !(in_xfer && in_start) |=> !drawing)
    else $error("drawing set without a start item");

  // a stalled sequencer keeps its octant
  a_oct_holds: assert property (@(posedge clk) disable iff (rst)
    job_valid && !pipe_en && !in_xfer |=> $stable(job_oct))
    else $error("octant moved during a stall");

  // end-of-circle results are last and carry no point
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata[2*MAT_BITS-1:0] == '0)
    else $error("malformed end-of-circle result");

endmodule

`default_nettype wire

/* tb/amcr_point_checker.sv */
`timescale 1ns / 1ps
// checker for the affine midpoint circle rasterizer: follows config writes,
// plots every accepted step and compares each result transfer in order
// depends on amcr_pkg
module amcr_point_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // center_x [15:0], center_y [31:16], radius [43:32], zero pad
  input  logic [amcr_pkg::S_TDATA_BITS-1:0] s_tdata,
  // kind [0]
  input  logic                              s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // point_x [31:0], point_y [63:32], octant [66:64], zero pad
  input  logic [amcr_pkg::M_TDATA_BITS-1:0] m_tdata,
  // point_valid [0], circle_done [1]
  input  logic [amcr_pkg::M_TUSER_BITS-1:0] m_tuser,
  input  logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [amcr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [amcr_pkg::MAT_BITS-1:0]     cfg_data,
  output int                                mismatch_count,
  output int                                points_due
);
  import amcr_pkg::*;

  typedef struct {
    logic [31:0] x_q;
    logic [31:0] y_q;
    logic        valid;
    logic [2:0]  oct;
    logic        last;
    logic        done;
  } plotted_t;

  plotted_t due_q[$];

  logic signed [31:0] mat_a, mat_b, mat_tx, mat_c, mat_d, mat_ty;
  int arc_x, arc_y, arc_dec, ctr_x, ctr_y;
  bit drawing;

  function automatic logic [31:0] clamp32(input longint acc);
    if (acc > 64'sh7fffffff) return 32'h7fffffff;
    if (acc < -64'sh80000000) return 32'h80000000;
    return acc[31:0];
  endfunction

  function automatic logic [31:0] map_row(input logic signed [31:0] m0, m1, t,
                                          input longint xx, yy);
    return clamp32(longint'(m0) * xx + longint'(m1) * yy + longint'(t));
  endfunction

  // one midpoint step: eight mapped points, or a single done marker
  function automatic void plot_step(input kind_t kind,
                                    input logic [S_TDATA_BITS-1:0] d);
    plotted_t p;
    longint u, v, xx, yy;
    logic [2:0] oct;
    int k;
    if (kind == KIND_START) begin
      ctr_x   = int'($signed(d[15:0]));
      ctr_y   = int'($signed(d[31:16]));
      arc_x   = 0;
      arc_y   = int'(d[43:32]);
      arc_dec = 1 - arc_y;
      drawing = 1'b1;
    end
    if (!drawing || arc_x >= arc_y) begin
      drawing = 1'b0;
      p = '{x_q: '0, y_q: '0, valid: 1'b0, oct: '0, last: 1'b1, done: 1'b1};
      due_q.push_back(p);
      return;
    end
    for (k = 0; k < 8; k++) begin
      oct = 3'(k);
      // bit 2 swaps the offsets, bit 1 mirrors x, bit 0 mirrors y
      u  = oct[2] ? arc_y : arc_x;
      v  = oct[2] ? arc_x : arc_y;
      xx = ctr_x + (oct[1] ? -u : u);
      yy = ctr_y + (oct[0] ? -v : v);
      p.x_q   = map_row(mat_a, mat_b, mat_tx, xx, yy);
      p.y_q   = map_row(mat_c, mat_d, mat_ty, xx, yy);
      p.valid = 1'b1;
      p.oct   = oct;
      p.last  = (k == 7);
      p.done  = 1'b0;
      due_q.push_back(p);
    end
    arc_x++;
    if (arc_dec < 0) begin
      arc_dec += 2 * arc_x + 1;
    end else begin
      arc_y--;
      arc_dec += 2 * arc_x + 1 - 2 * arc_y;
    end
  endfunction

  function automatic void check_field(input string name, input longint want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    plotted_t want;
    if (rst) begin
      due_q.delete();
      mat_a   = MAT_ONE;
      mat_b   = '0;
      mat_tx  = '0;
      mat_c   = '0;
      mat_d   = MAT_ONE;
      mat_ty  = '0;
      arc_x   = 0;
      arc_y   = 0;
      arc_dec = 0;
      ctr_x   = 0;
      ctr_y   = 0;
      drawing = 1'b0;
      mismatch_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          $error("result transfer with no point due");
          mismatch_count++;
        end else begin
          want = due_q.pop_front();
          check_field("point_x", longint'($signed(want.x_q)),
                      longint'($signed(m_tdata[31:0])));
          check_field("point_y", longint'($signed(want.y_q)),
                      longint'($signed(m_tdata[63:32])));
          check_field("point_valid", want.valid, m_tuser[0]);
          check_field("octant", want.oct, m_tdata[66:64]);
          check_field("last_of_step", want.last, m_tlast);
          check_field("circle_done", want.done, m_tuser[1]);
        end
      end
      if (s_tvalid && s_tready) plot_step(kind_t'(s_tuser), s_tdata);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAT_A:  mat_a  = cfg_data;
          REG_MAT_B:  mat_b  = cfg_data;
          REG_MAT_TX: mat_tx = cfg_data;
          REG_MAT_C:  mat_c  = cfg_data;
          REG_MAT_D:  mat_d  = cfg_data;
          REG_MAT_TY: mat_ty = cfg_data;
          default: ;
        endcase
      end
    end
    points_due = due_q.size();
  end

endmodule

/* tb/affine_midpoint_circle_raster_test.sv */
`timescale 1ns / 1ps
// testbench top for affine_midpoint_circle_raster: clock, reset, stimulus,
// receiver stalls and verdict; depends on amcr_pkg and amcr_point_checker
module affine_midpoint_circle_raster_test;
  import amcr_pkg::*;

  localparam int LIMIT       = 250000;
  localparam int HOLD_AT     = 700;  // result count that triggers the long stall
  localparam int HOLD_CYCLES = 150;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // center_x [15:0], center_y [31:16], radius [43:32], zero pad
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  // kind [0]
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  // point_x [31:0], point_y [63:32], octant [66:64], zero pad
  logic [M_TDATA_BITS-1:0] m_tdata;
  // point_valid [0], circle_done [1]
  logic [M_TUSER_BITS-1:0] m_tuser;
  logic                    m_tlast;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [MAT_BITS-1:0]     cfg_data = '0;

  int mismatch_count, points_due;
  int sent, cycle_count, rx_count, rx_wait, rx_hold;
  bit steady;   // no idling on either side while set
  bit rx_fire;

  always #2 clk = ~clk;

  affine_midpoint_circle_raster dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  amcr_point_checker points (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatch_count, .points_due
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random wait before each result, one long stall part way through
  always @(posedge clk) rx_fire <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (rx_fire) begin
      rx_count++;
      rx_wait = steady ? 0 : $urandom_range(0, 3);
      if (rx_count == HOLD_AT) rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // offer one item after a random gap and hold it until the transfer
  task automatic push_item(input kind_t kind, input logic [15:0] cx, cy,
                           input logic [11:0] r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, r, cy, cx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  // sender pause until every expected point has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    while (points_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // start a circle then step it; advances carry random junk in tdata
  task automatic run_circle(input logic [15:0] cx, cy, input logic [11:0] r,
                            input int advances);
    push_item(KIND_START, cx, cy, r);
    repeat (advances) push_item(KIND_ADVANCE, 16'($urandom), 16'($urandom),
                                12'($urandom));
  endtask

  // write all six matrix entries back to back, block idle
  task automatic load_matrix(input logic [31:0] a, b, tx, c, d, ty);
    logic [31:0] vals [6];
    vals = '{a, b, tx, c, d, ty};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // signed Q16.16 in roughly [-4.0, 4.0]
  function automatic logic [31:0] near_unit();
    return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
  endfunction

  initial begin
    int pick, target;
    logic [11:0] r;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, under the reset matrix
    push_item(KIND_ADVANCE, '0, '0, '0);              // advance while idle
    run_circle(16'd0, 16'd0, 12'd0, 1);                // zero radius, then idle advance
    run_circle(16'd0, 16'd0, 12'd1, 2);                // smallest circle to done
    run_circle(16'h7fff, 16'h8000, 12'hfff, 2);        // extreme center and radius
    run_circle(16'h8000, 16'h7fff, 12'hfff, 1);
    run_circle(16'd100, 16'hff9c, 12'd6, 6);           // full circle to completion
    run_circle(16'hffff, 16'h0001, 12'd9, 1);          // restart while drawing
    run_circle(16'h5555, 16'haaaa, 12'h555, 1);
    push_item(KIND_START, 16'haaaa, 16'h5555, 12'haaa);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_matrix(MAT_ONE, '0, $urandom, '0, MAT_ONE, $urandom);
        1: load_matrix('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1);
        2: load_matrix(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000);
        5: load_matrix(32'h7fffffff, 32'h80000000, near_unit(),
                       32'h80000000, 32'h7fffffff, 32'h7fffffff);
        4, 7: load_matrix($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
        default: load_matrix(near_unit(), near_unit(), $urandom, near_unit(),
                             near_unit(), $urandom);
      endcase
      steady = (phase % 3 == 2);
      target = sent + 58;
      while (sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // well-formed circle: small ones stepped to done and a bit past, large ones up to five advances
          if ($urandom_range(0, 9) == 0) begin
            r = 12'($urandom);
            run_circle(16'($urandom), 16'($urandom), r, $urandom_range(0, 5));
          end else begin
            r = 12'($urandom_range(0, 24));
            run_circle(16'($urandom), 16'($urandom), r,
                       (r * 3) / 4 + 1 + $urandom_range(0, 1) - (r == 0));
          end
        end else if (pick < 90) begin
          push_item(KIND_ADVANCE, 16'($urandom), 16'($urandom), 12'($urandom));
        end else begin
          // cut short before done (but for the smallest radii); a later start abandons it
          run_circle(16'($urandom), 16'($urandom), 12'($urandom_range(2, 40)),
                     $urandom_range(0, 3));
        end
      end
    end

    drain();
    repeat (12) @(negedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
